@@ rtl/vdd_pkg.sv @@
package vdd_pkg;

  localparam int MAX_POINTS_DEF = 65536;
  localparam int COORD_BITS_DEF = 24;

  localparam int TOL_W      = 51;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 51;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GEOMETRY_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_SQUARED = 2'd2;

  // Geometry modes; any code above MODE_RING passes everything through.
  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_RING = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result queue depth; an item may push two results in one cycle.
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

@@ rtl/vdd_in_stage.sv @@
module vdd_in_stage import vdd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic                  in_last_point,
  input  logic                  take,
  output logic                  s1_valid,
  output logic [COORD_BITS-1:0] s1_x,
  output logic [COORD_BITS-1:0] s1_y,
  output logic                  s1_last
);

  logic                  valid_r, valid_nxt;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic                  last_r;
  logic                  load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= in_x_coord;
      y_r    <= in_y_coord;
      last_r <= in_last_point;
    end
  end

  assign s1_valid = valid_r;
  assign s1_x     = x_r;
  assign s1_y     = y_r;
  assign s1_last  = last_r;

endmodule

@@ rtl/vdd_core.sv @@
module vdd_core import vdd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1),
  localparam int RES_W     = 2 * COORD_BITS + CNT_W + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  input  logic [COORD_BITS-1:0] x,
  input  logic [COORD_BITS-1:0] y,
  input  logic                  last,
  output push_t                 push,
  output logic [RES_W-1:0]      res0,
  output logic [RES_W-1:0]      res1
);

  localparam int CB    = COORD_BITS;
  localparam int SUM_W = 2 * CB + 1;
  localparam int CMP_W = (SUM_W > TOL_W) ? SUM_W : TOL_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  logic [1:0]       mode_r;
  logic             filt_r;
  logic [TOL_W-1:0] tol_r;

  logic [CB-1:0]    lk_x_r, lk_y_r, lk_x_nxt, lk_y_nxt;
  logic [CB-1:0]    first_x_r, first_y_r, first_x_nxt, first_y_nxt;
  logic [CNT_W-1:0] in_cnt_r, out_cnt_r, in_cnt_nxt, out_cnt_nxt;
  logic             at_start_r, at_start_nxt;

  logic             ring, pass, closes, keep, emit0;
  logic signed [CB:0] dx, dy;
  logic [CB-1:0]    mx, my;
  logic [2*CB-1:0]  sqx, sqy;
  logic [SUM_W-1:0] sq_dist;
  logic             far;
  logic [CB-1:0]    fx, fy;
  logic [CNT_W-1:0] in_after, out_after, sum_cnt;
  logic             sum_chg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINE;
      filt_r <= 1'b1;
      tol_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GEOMETRY_MODE:     mode_r <= cfg_data[1:0];
        CFG_FILTER_ENABLE:     filt_r <= cfg_data[0];
        CFG_TOLERANCE_SQUARED: tol_r  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign ring = (mode_r == MODE_RING);
  assign pass = !((mode_r == MODE_LINE) || (mode_r == MODE_RING));

  // Squared distance to the last kept vertex. The difference of two
  // coordinates never reaches 2^CB in magnitude, so CB bits hold it.
  assign dx  = {x[CB-1], x} - {lk_x_r[CB-1], lk_x_r};
  assign dy  = {y[CB-1], y} - {lk_y_r[CB-1], lk_y_r};
  assign mx  = dx[CB] ? (~dx[CB-1:0] + 1'b1) : dx[CB-1:0];
  assign my  = dy[CB] ? (~dy[CB-1:0] + 1'b1) : dy[CB-1:0];
  assign sqx = mx * mx;
  assign sqy = my * my;
  assign sq_dist = {1'b0, sqx} + {1'b0, sqy};
  assign far     = CMP_W'(sq_dist) > CMP_W'(tol_r);

  assign closes = ring && last;
  assign keep   = at_start_r || pass || !filt_r || far;
  assign emit0  = closes || keep;

  // The closing vertex of a one-vertex ring is the vertex itself.
  assign fx = at_start_r ? x : first_x_r;
  assign fy = at_start_r ? y : first_y_r;

  assign in_after  = (in_cnt_r < MAX_CNT) ? in_cnt_r + 1'b1 : in_cnt_r;
  assign out_after = !emit0 ? out_cnt_r :
                     ((out_cnt_r < MAX_CNT) ? out_cnt_r + 1'b1 : out_cnt_r);
  assign sum_cnt   = pass ? in_after : out_after;
  assign sum_chg   = !pass && (out_after != in_after);

  always_comb begin
    lk_x_nxt     = lk_x_r;
    lk_y_nxt     = lk_y_r;
    first_x_nxt  = first_x_r;
    first_y_nxt  = first_y_r;
    in_cnt_nxt   = in_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    at_start_nxt = at_start_r;
    if (take) begin
      first_x_nxt = fx;
      first_y_nxt = fy;
      if (!closes && keep) begin
        lk_x_nxt = x;
        lk_y_nxt = y;
      end
      if (last) begin
        in_cnt_nxt   = '0;
        out_cnt_nxt  = '0;
        at_start_nxt = 1'b1;
      end else begin
        in_cnt_nxt   = in_after;
        out_cnt_nxt  = out_after;
        at_start_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r   <= '0;
      out_cnt_r  <= '0;
      at_start_r <= 1'b1;
    end else begin
      in_cnt_r   <= in_cnt_nxt;
      out_cnt_r  <= out_cnt_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lk_x_r    <= lk_x_nxt;
    lk_y_r    <= lk_y_nxt;
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
  end

  assign push.first  = take && emit0;
  assign push.second = take && last;

  assign res0 = {KIND_VERTEX, (closes ? fx : x), (closes ? fy : y),
                 {CNT_W{1'b0}}, 1'b0, 1'b0};
  assign res1 = {KIND_SUMMARY, {CB{1'b0}}, {CB{1'b0}}, sum_cnt, sum_chg, 1'b1};

  a_summary_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> (take && last))
    else $error("summary pushed for a vertex that does not end the geometry");

  a_restart_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |=> (at_start_r && in_cnt_r == '0 && out_cnt_r == '0))
    else $error("geometry state not cleared after its summary");

  a_kept_not_above_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= in_cnt_r)
    else $error("kept count exceeds input count");

  a_start_keeps_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (take && at_start_r) |-> push.first)
    else $error("first vertex of a geometry was dropped");

endmodule

@@ rtl/vdd_out_queue.sv @@
module vdd_out_queue import vdd_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  push_t        push,
  input  logic [W-1:0] d0,
  input  logic [W-1:0] d1,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] dout
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt, wr1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = mem_r[rd_ptr_r];
  // Room for two results, so a transfer out is never needed to take an item.
  assign room      = (cnt_r <= CNT_W'(QDEPTH - 2));

  // The second result follows the first, or takes its slot if there is none.
  assign wr1 = wr_ptr_r + PTR_W'(push.first);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.first) + PTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wr_ptr_r] <= d0;
    end
    if (push.second) begin
      mem_r[wr1] <= d1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == rd_ptr_r + PTR_W'(cnt_r))
    else $error("result queue pointers disagree with fill level");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.first || push.second) |-> $past(room) || !$past(rst_n) || room)
    else $error("result pushed without room");

endmodule

@@ rtl/vertex_distance_decimator.sv @@
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   x_coord, y_coord, last_point
// out_      output     out_valid / out_ready item_kind, out_x, out_y, kept_count,
//                                            changed, end_of_run
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// One vertex per cycle while the result queue has room: a vertex is held in the
// input register, then the squared-distance compare against the last kept
// vertex decides it in one pass. A vertex that ends a geometry yields up to two
// results, which leave the output one at a time; the four-entry result queue
// sets the pace. Reset is synchronous and active low; it restores the register
// defaults and clears the geometry state. A stalled output fills the queue and
// then holds in_ready low; nothing is dropped.
module vertex_distance_decimator import vdd_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_x_coord,
  input  logic [COORD_BITS-1:0] in_y_coord,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_item_kind,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [CNT_W-1:0]      out_kept_count,
  output logic                  out_changed,
  output logic                  out_end_of_run
);

  localparam int RES_W = 2 * COORD_BITS + CNT_W + 3;

  logic                  s1_valid, s1_last, take, room;
  logic [COORD_BITS-1:0] s1_x, s1_y;
  push_t                 push;
  logic [RES_W-1:0]      res0, res1, dout;

  assign take = s1_valid && room;

  vdd_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk, .rst_n, .in_valid, .in_ready, .in_x_coord, .in_y_coord, .in_last_point,
    .take, .s1_valid, .s1_x, .s1_y, .s1_last
  );

  vdd_core #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_core (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .take,
    .x(s1_x), .y(s1_y), .last(s1_last), .push, .res0, .res1
  );

  vdd_out_queue #(.W(RES_W)) u_q (
    .clk, .rst_n, .push, .d0(res0), .d1(res1), .room,
    .out_valid, .out_ready, .dout
  );

  assign {out_item_kind, out_x, out_y, out_kept_count, out_changed, out_end_of_run} = dout;

endmodule

@@ bench/vertex_distance_decimator_test.sv @@
import vdd_pkg::*;

localparam int COORD_W = COORD_BITS_DEF;
localparam int KEPT_W  = $clog2(MAX_POINTS_DEF + 1);

// Mode code above MODE_PASS; the block treats it as pass-through.
localparam logic [1:0] MODE_SPARE = 2'd3;
// Index with no register behind it; writes to it are ignored.
localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

typedef struct packed {
  logic                    kind;
  logic [COORD_W-1:0]      x;
  logic [COORD_W-1:0]      y;
  logic [KEPT_W-1:0]       count;
  logic                    changed;
  logic                    eor;
} decim_result_t;

class decimation_checker;
  logic [1:0]              mode;
  logic                    filt;
  logic [CFG_DATA_W-1:0]   tol;
  logic signed [COORD_W-1:0] kept_x, kept_y, first_x, first_y;
  int unsigned             n_in, n_out;
  bit                      at_start;
  decim_result_t           due_results[$];
  int                      mismatches;

  function new();
    mode = MODE_LINE;
    filt = 1'b1;
    tol = '0;
    kept_x = '0;
    kept_y = '0;
    first_x = '0;
    first_y = '0;
    n_in = 0;
    n_out = 0;
    at_start = 1'b1;
    mismatches = 0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GEOMETRY_MODE: mode = data[1:0];
      CFG_FILTER_ENABLE: filt = data[0];
      CFG_TOLERANCE_SQUARED: tol = data;
      default: ;
    endcase
  endfunction

  function int unsigned bump(int unsigned c);
    return (c < MAX_POINTS_DEF) ? c + 1 : c;
  endfunction

  function void push_result(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            int unsigned cnt, logic chg);
    decim_result_t r;
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.count = KEPT_W'(cnt);
    r.changed = chg;
    r.eor = (kind == KIND_SUMMARY);
    due_results.push_back(r);
  endfunction

  // Works out what one accepted vertex should produce.
  function void predict_vertex(logic [COORD_W-1:0] xin, logic [COORD_W-1:0] yin, logic last);
    logic signed [COORD_W-1:0] x, y;
    logic ring, pass, keep;
    longint dx, dy;
    longint unsigned sq_dist;
    x = xin;
    y = yin;
    ring = (mode == MODE_RING);
    pass = (mode >= MODE_PASS);
    n_in = bump(n_in);
    if (at_start) begin
      first_x = x;
      first_y = y;
    end
    if (!(ring && last)) begin
      keep = at_start || pass || !filt;
      if (!keep) begin
        dx = longint'(x) - longint'(kept_x);
        dy = longint'(y) - longint'(kept_y);
        sq_dist = longint'(dx * dx) + longint'(dy * dy);
        keep = sq_dist > {13'b0, tol};
      end
      if (keep) begin
        kept_x = x;
        kept_y = y;
        n_out = bump(n_out);
        push_result(KIND_VERTEX, x, y, 0, 1'b0);
      end
    end else begin
      // The ring is closed with the vertex stored when the geometry began.
      n_out = bump(n_out);
      push_result(KIND_VERTEX, first_x, first_y, 0, 1'b0);
    end
    at_start = 1'b0;
    if (last) begin
      push_result(KIND_SUMMARY, '0, '0, pass ? n_in : n_out,
                  pass ? 1'b0 : (n_out != n_in));
      n_in = 0;
      n_out = 0;
      at_start = 1'b1;
    end
  endfunction

  function void flag(string what, decim_result_t want, decim_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%s: expected kind=%0d x=%0d y=%0d count=%0d changed=%0d eor=%0d, ",
             what, want.kind, $signed(want.x), $signed(want.y), want.count, want.changed,
             want.eor);
      $display("got kind=%0d x=%0d y=%0d count=%0d changed=%0d eor=%0d",
               got.kind, $signed(got.x), $signed(got.y), got.count, got.changed,
               got.eor);
    end
  endfunction

  function void compare_result(decim_result_t got);
    decim_result_t want;
    if (due_results.size() == 0) begin
      flag("result with nothing due", '0, got);
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
        got.count !== want.count || got.changed !== want.changed || got.eor !== want.eor)
      flag("result mismatch", want, got);
  endfunction

  function int outstanding();
    return due_results.size();
  endfunction
endclass

module vertex_distance_decimator_test;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 500;
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [CFG_DATA_W-1:0] TOL_MAX = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    in_x_coord;
  logic [COORD_W-1:0]    in_y_coord;
  logic                  in_last_point;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_item_kind;
  logic [COORD_W-1:0]    out_x;
  logic [COORD_W-1:0]    out_y;
  logic [KEPT_W-1:0]     out_kept_count;
  logic                  out_changed;
  logic                  out_end_of_run;

  decimation_checker decim = new();
  decim_result_t observed;
  int  idle_cycles = 0;
  int  hold_cycles = 0;
  int  burst_left = 0;
  int  vertices_sent = 0;

  vertex_distance_decimator DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .in_last_point(in_last_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item_kind(out_item_kind),
    .out_x(out_x),
    .out_y(out_y),
    .out_kept_count(out_kept_count),
    .out_changed(out_changed),
    .out_end_of_run(out_end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Inputs are noted before results so that a transfer on both sides sees current state.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        decim.predict_vertex(in_x_coord, in_y_coord, in_last_point);
      if (out_valid && out_ready) begin
        observed.kind = out_item_kind;
        observed.x = out_x;
        observed.y = out_y;
        observed.count = out_kept_count;
        observed.changed = out_changed;
        observed.eor = out_end_of_run;
        decim.compare_result(observed);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: segments of differing stall styles, plus a long hold-off on request.
  initial begin
    int  style, period, left;
    logic rdy;
    left = 0;
    style = 0;
    period = 2;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
          period = $urandom_range(2, 9);
        end
        left--;
        case (style)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 7) != 0);
          default: rdy = ((left % period) != 0);
        endcase
        out_ready <= rdy;
        @(posedge clk);
      end
    end
  end

  task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0)
      burst_left--;
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertices_sent++;
  endtask

  // Stops offering and waits until every due result has arrived and dropped
  // vertices have left the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decim.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    decim.set_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [1:0] mode, input logic filt,
                                input logic [CFG_DATA_W-1:0] tol);
    write_register(CFG_GEOMETRY_MODE, CFG_DATA_W'(mode));
    write_register(CFG_FILTER_ENABLE, CFG_DATA_W'(filt));
    write_register(CFG_TOLERANCE_SQUARED, tol);
  endtask

  // A random walk with an occasional jump anywhere in the coordinate range.
  task automatic send_walk(input int len, input int reach);
    logic [COORD_W-1:0] x, y;
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end else begin
          x = x + COORD_W'($urandom_range(0, 2 * reach)) - COORD_W'(reach);
          y = y + COORD_W'($urandom_range(0, 2 * reach)) - COORD_W'(reach);
        end
      end
      send_vertex(x, y, i == len - 1);
    end
  endtask

  initial begin
    int  phase, random_start, pick, sc, reach, len;
    logic [1:0] mode;
    logic filt;
    logic [CFG_DATA_W-1:0] tol;
    longint r;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_x_coord <= '0;
    in_y_coord <= '0;
    in_last_point <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: open line, filtering on, zero tolerance. A repeated
    // vertex is at distance zero and is dropped.
    send_vertex('0, '0, 1'b0);
    send_vertex('0, '0, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b1);
    send_vertex(COORD_W'(1), COORD_W'(-1), 1'b1);

    // Largest tolerance: only the first vertex survives.
    drain();
    write_register(CFG_TOLERANCE_SQUARED, TOL_MAX);
    send_vertex(COORD_W'(5), COORD_W'(5), 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);

    // Ring closure, then a ring made of a single vertex.
    drain();
    write_settings(MODE_RING, 1'b1, CFG_DATA_W'(100));
    send_vertex('0, '0, 1'b0);
    send_vertex(COORD_W'(3), COORD_W'(4), 1'b0);
    send_vertex(COORD_W'(20), '0, 1'b0);
    send_vertex('0, '0, 1'b1);
    send_vertex(COORD_W'(7), COORD_W'(-7), 1'b1);

    // Mode switched while a ring is half done; the closure still uses its first vertex.
    send_vertex(COORD_W'(10), COORD_W'(10), 1'b0);
    send_vertex(COORD_W'(500), COORD_W'(500), 1'b0);
    drain();
    write_register(CFG_GEOMETRY_MODE, CFG_DATA_W'(MODE_LINE));
    send_vertex(COORD_W'(1000), COORD_W'(1000), 1'b0);
    drain();
    write_register(CFG_GEOMETRY_MODE, CFG_DATA_W'(MODE_RING));
    send_vertex(COORD_W'(3), COORD_W'(3), 1'b1);

    // Pass-through ignores the tolerance.
    drain();
    write_settings(MODE_PASS, 1'b1, TOL_MAX);
    send_vertex(COORD_W'(1), COORD_W'(1), 1'b0);
    send_vertex(COORD_W'(1), COORD_W'(1), 1'b0);
    send_vertex(COORD_W'(2), COORD_W'(2), 1'b1);

    // Upper data bits are masked off: this selects the spare mode code.
    drain();
    write_register(CFG_GEOMETRY_MODE, {{(CFG_DATA_W-3){1'b1}}, 3'b111});
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b1);

    // A write to the unused index changes nothing; filtering off keeps duplicates.
    drain();
    write_register(CFG_UNUSED, '1);
    write_register(CFG_GEOMETRY_MODE, CFG_DATA_W'(MODE_LINE));
    write_register(CFG_FILTER_ENABLE, {{(CFG_DATA_W-1){1'b1}}, 1'b0});
    send_vertex('0, '0, 1'b0);
    send_vertex('0, '0, 1'b0);
    send_vertex('0, '0, 1'b1);

    random_start = vertices_sent;
    phase = 0;
    while (vertices_sent - random_start < RANDOM_ITEMS) begin
      drain();
      pick = $urandom_range(0, 19);
      mode = (pick < 8) ? MODE_LINE : (pick < 15) ? MODE_RING :
             (pick < 18) ? MODE_PASS : MODE_SPARE;
      filt = ($urandom_range(0, 6) != 0);
      sc = $urandom_range(0, 14);
      reach = (1 << sc) + 2;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        tol = '0;
      end else if (pick == 1) begin
        tol = TOL_MAX;
        reach = 1 << $urandom_range(0, 22);
      end else if (pick == 2) begin
        tol = CFG_DATA_W'({$urandom, $urandom});
        reach = 1 << $urandom_range(0, 22);
      end else begin
        r = $urandom_range(0, 1 << sc);
        tol = CFG_DATA_W'(r * r);
      end
      write_settings(mode, filt, tol);
      // Receiver holds off while the sender keeps offering, so the block backs up.
      if (phase == 3) begin
        hold_cycles = HOLD_CYCLES;
        send_walk(80, reach);
      end
      repeat ($urandom_range(2, 5)) begin
        pick = $urandom_range(0, 9);
        len = (pick == 0) ? 1 : (pick == 1) ? $urandom_range(40, 80) : $urandom_range(2, 24);
        send_walk(len, reach);
      end
      phase++;
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (decim.outstanding() != 0)
      $display("%0d results still due at the end", decim.outstanding());
    if (decim.mismatches == 0 && decim.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
